// ===== rtl/core/ptm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants for the page table map unit: commands, status codes,
// register indexes, entry format and field widths.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int FRAME_W = 40;
	localparam int WORD_W  = 64;
	localparam int EPOCH_W = 8;   // per-page generation tag kept with every word
	localparam int IDX_W   = 9;
	localparam int CFGP_W  = 6;   // width of page-sized config fields
	localparam int NFREE_W = 7;

	typedef enum logic {
		CMD_MAP  = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_PAGE = 2'd1,
		STAT_BAD_FRM = 2'd2,
		STAT_RSVD    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_ROOT_PAGE  = 2'd0,
		REG_POOL_BASE  = 2'd1,
		REG_FREE_FIRST = 2'd2,
		REG_FREE_LAST  = 2'd3
	} reg_idx_t;

	localparam logic [11:0]         ENTRY_FLAGS     = 12'h007;
	localparam logic [CFGP_W-1:0]   ROOT_RST        = 6'd0;
	localparam logic [FRAME_W-1:0]  BASE_RST        = 40'd0;
	localparam logic [CFGP_W-1:0]   FREE_FIRST_RST  = 6'd1;
	localparam logic [CFGP_W-1:0]   FREE_LAST_RST   = 6'd63;
	localparam logic [1:0]          LEAF_LVL        = 2'd3;

endpackage

// ===== rtl/core/ptm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/page_table_map_with_allocation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_with_allocation
// Four-level page table walker with a built-in ascending page allocator.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one command per transfer (tuser = cmd). A map walks the four
//   table levels in the local store, allocating zeroed pages for empty
//   entries and always for the leaf; a read returns one stored word.
//   m_* gives one result per command. cfg_* writes the four registers; it is
//   ready only while no command is being walked and is meant to be used
//   while no command is in flight.
// Sequence:
//   One command at a time. A read of a page in range passes the walk,
//   check and done states before its result is loaded. A map passes walk
//   and check for each followed level, and walk, check, alloc, generation
//   bump and entry write for each allocating level. Pages are zeroed
//   lazily through a per-page 8-bit generation tag; when a page's tag wraps
//   (every 256th allocation of it) a sweep of all 512 words of the page is added.
// Reset:
//   After arst_n the store is cleared one word a cycle, all PAGE_COUNT*512
//   words, with s_tready and cfg_ready low. Registers take their reset
//   values at once.
// Stall:
//   The result sits in an output register; the next command is accepted
//   while it waits, and its own result is held until m_tready frees it.
// ----------------------------------------------------------------------------
module page_table_map_with_allocation #(
	parameter int PAGE_COUNT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // virt_addr[47:0], read_page[53:48], read_index[62:54]
	input  logic         s_tuser,   // cmd
	// stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // status[1:0], leaf_frame[41:2], tables_made[43:42],
	                                // read_data[107:44]
	// configuration
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [39:0]  cfg_data
);

	import ptm_pkg::*;

	localparam int PW    = $clog2(PAGE_COUNT);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = PAGE_COUNT * 512;
	localparam int CMPW  = (PW + 1 > NFREE_W) ? PW + 1 : NFREE_W;
	localparam int DW    = EPOCH_W + WORD_W;
	localparam logic [CMPW-1:0] PC_C   = CMPW'(PAGE_COUNT);
	localparam logic [51:0]     PC_52  = 52'(PAGE_COUNT);
	localparam logic [AW-1:0]   LAST_A = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_CHK,
		ST_ALLOC,
		ST_ALLOC_EP,
		ST_SWEEP,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [CFGP_W-1:0]  root_q, free_last_q;
	logic [FRAME_W-1:0] base_q;
	logic [NFREE_W-1:0] next_free_q;

	// command context
	logic               is_read_q;
	logic [35:0]        va_q;
	logic [IDX_W-1:0]   rix_q;
	logic [1:0]         lvl_q;
	logic [PW-1:0]      cur_q;
	logic [EPOCH_W-1:0] cur_ep_q;
	logic [PW-1:0]      np_q;
	logic [AW-1:0]      cnt_q;
	logic [1:0]         made_q;
	logic [1:0]         status_q;
	logic [FRAME_W-1:0] leaf_q;
	logic [WORD_W-1:0]  rdata_q;

	logic               m_tvalid_q;
	logic [111:0]       m_tdata_q;

	// memory ports
	logic               d_we;
	logic [AW-1:0]      d_waddr, d_raddr;
	logic [DW-1:0]      d_wdata, d_rdata;
	logic               e_we;
	logic [PW-1:0]      e_waddr, e_raddr;
	logic [EPOCH_W-1:0] e_wdata, e_rdata;

	// datapath helpers
	logic [IDX_W-1:0]   cur_idx;
	logic [CMPW-1:0]    nf_ext, root_ext, rpg_ext;
	logic [PW-1:0]      alloc_pg;
	logic               exhausted;
	logic [WORD_W-1:0]  word;
	logic [51:0]        fr, base52, fr_diff;
	logic               frame_bad;
	logic [EPOCH_W-1:0] ep_inc;
	logic [FRAME_W-1:0] new_frame;
	logic [WORD_W-1:0]  new_entry;

	logic               in_xfer;
	logic               out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		case (lvl_q)
			2'd0:    cur_idx = va_q[35:27];
			2'd1:    cur_idx = va_q[26:18];
			2'd2:    cur_idx = va_q[17:9];
			default: cur_idx = va_q[8:0];
		endcase
		if (is_read_q) begin
			cur_idx = rix_q;
		end
	end

	assign nf_ext    = CMPW'(next_free_q);
	assign root_ext  = CMPW'(root_q);
	assign rpg_ext   = CMPW'(s_tdata[53:48]);
	assign alloc_pg  = nf_ext[PW-1:0];
	assign exhausted = (next_free_q > {1'b0, free_last_q}) || (nf_ext >= PC_C);

	// a word written under an older generation of its page reads as zero
	assign word      = (d_rdata[DW-1:WORD_W] == e_rdata) ? d_rdata[WORD_W-1:0] : '0;
	assign fr        = word[63:12];
	assign base52    = {12'b0, base_q};
	assign fr_diff   = fr - base52;
	assign frame_bad = (fr < base52) || (fr_diff >= PC_52);

	assign ep_inc    = e_rdata + EPOCH_W'(1);
	assign new_frame = base_q + FRAME_W'(np_q);
	assign new_entry = {12'b0, new_frame, ENTRY_FLAGS};

	always_comb begin
		d_we    = 1'b0;
		d_waddr = {cur_q, cur_idx};
		d_wdata = {cur_ep_q, new_entry};
		d_raddr = {cur_q, cur_idx};
		e_we    = 1'b0;
		e_waddr = np_q;
		e_wdata = ep_inc;
		e_raddr = (state_q == ST_ALLOC) ? alloc_pg : cur_q;
		case (state_q)
			ST_CLEAR: begin
				d_we    = 1'b1;
				d_waddr = cnt_q;
				d_wdata = '0;
				e_we    = 1'b1;
				e_waddr = cnt_q[AW-1:IDX_W];
				e_wdata = '0;
			end
			ST_ALLOC_EP: begin
				e_we = 1'b1;
			end
			ST_SWEEP: begin
				d_we    = 1'b1;
				d_waddr = {np_q, cnt_q[IDX_W-1:0]};
				d_wdata = '0;
			end
			ST_WRITE: begin
				d_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ptm_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	ptm_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (PAGE_COUNT)
	) u_epoch (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
			root_q       <= ROOT_RST;
			base_q       <= BASE_RST;
			free_last_q  <= FREE_LAST_RST;
			next_free_q  <= NFREE_W'(FREE_FIRST_RST);
		end else begin
			// in ST_DONE the output register is reloaded below instead
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						is_read_q <= (s_tuser == CMD_READ);
						va_q      <= s_tdata[47:12];
						rix_q     <= s_tdata[62:54];
						lvl_q     <= 2'd0;
						made_q    <= 2'd0;
						status_q  <= STAT_OK;
						leaf_q    <= '0;
						rdata_q   <= '0;
						if (s_tuser == CMD_READ) begin
							cur_q   <= rpg_ext[PW-1:0];
							state_q <= (rpg_ext >= PC_C) ? ST_DONE : ST_WALK;
						end else if (root_ext >= PC_C) begin
							status_q <= STAT_BAD_FRM;
							state_q  <= ST_DONE;
						end else begin
							cur_q   <= root_ext[PW-1:0];
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cur_ep_q <= e_rdata;
					if (is_read_q) begin
						rdata_q <= word;
						state_q <= ST_DONE;
					end else if (lvl_q == LEAF_LVL || word == '0) begin
						state_q <= ST_ALLOC;
					end else if (frame_bad) begin
						status_q <= STAT_BAD_FRM;
						state_q  <= ST_DONE;
					end else begin
						cur_q   <= fr_diff[PW-1:0];
						lvl_q   <= lvl_q + 2'd1;
						state_q <= ST_WALK;
					end
				end
				ST_ALLOC: begin
					if (exhausted) begin
						status_q <= STAT_NO_PAGE;
						state_q  <= ST_DONE;
					end else begin
						np_q        <= alloc_pg;
						next_free_q <= next_free_q + NFREE_W'(1);
						state_q     <= ST_ALLOC_EP;
					end
				end
				ST_ALLOC_EP: begin
					// bumping the generation empties the page; the entry write that
					// follows may land in this same page
					if (cur_q == np_q) begin
						cur_ep_q <= ep_inc;
					end
					cnt_q   <= '0;
					state_q <= (ep_inc == '0) ? ST_SWEEP : ST_WRITE;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q[IDX_W-1:0] == '1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (lvl_q == LEAF_LVL) begin
						leaf_q  <= new_frame;
						state_q <= ST_DONE;
					end else begin
						made_q  <= made_q + 2'd1;
						cur_q   <= np_q;
						lvl_q   <= lvl_q + 2'd1;
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, rdata_q, made_q, leaf_q, status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROOT_PAGE:  root_q <= cfg_data[CFGP_W-1:0];
					REG_POOL_BASE:  base_q <= cfg_data;
					REG_FREE_FIRST: begin
						next_free_q  <= {1'b0, cfg_data[CFGP_W-1:0]};
					end
					REG_FREE_LAST:  free_last_q <= cfg_data[CFGP_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_table_map_with_allocation. A shadow copy of
// the table store and allocator predicts the result of every accepted
// command: map walks, page allocation, exhaustion, bad frames and reads.
// A directed pass hits the corner cases, then random phases vary the
// registers, the address mix and the idle pattern on both streams.
// ----------------------------------------------------------------------------
module tb;
	import ptm_pkg::*;

	localparam int PAGES           = 64;
	localparam int WATCHDOG_CYCLES = 150000;  // covers the post-reset store clear
	localparam int PHASES          = 22;
	localparam int PHASE_ITEMS     = 60;
	localparam int HOLD_CYCLES     = 400;

	typedef struct {
		status_t     status;
		bit [39:0]   leaf;
		bit [1:0]    made;
		bit [63:0]   rdata;
	} walk_outcome_t;

	class walk_shadow;
		bit [63:0]     words [PAGES*512];
		bit [5:0]      root_pg;
		bit [39:0]     base_frame;
		bit [5:0]      first_pg;
		bit [5:0]      last_pg;
		bit [6:0]      next_pg;
		walk_outcome_t pending_outcomes [$];
		int            errors;
		int            n_map;
		int            n_read;
		int            tables_total;
		int            stat_cnt [4];

		function new();
			root_pg    = ROOT_RST;
			base_frame = BASE_RST;
			first_pg   = FREE_FIRST_RST;
			last_pg    = FREE_LAST_RST;
			next_pg    = {1'b0, FREE_FIRST_RST};
		endfunction

		function void write_reg(reg_idx_t idx, bit [39:0] val);
			case (idx)
				REG_ROOT_PAGE: root_pg = val[5:0];
				REG_POOL_BASE: base_frame = val;
				REG_FREE_FIRST: begin
					first_pg = val[5:0];
					next_pg  = {1'b0, val[5:0]};
				end
				REG_FREE_LAST: last_pg = val[5:0];
				default: ;
			endcase
		endfunction

		// hands out the next page and zeroes it; 0 when the range is used up
		function bit grab_page(output bit [5:0] pg);
			if (next_pg > {1'b0, last_pg} || next_pg >= PAGES)
				return 1'b0;
			pg = next_pg[5:0];
			next_pg++;
			for (int w = 0; w < 512; w++)
				words[{pg, 9'(w)}] = '0;
			return 1'b1;
		endfunction

		function void note_command(cmd_t cmd, bit [47:0] va, bit [5:0] rpg, bit [8:0] rix);
			walk_outcome_t r;
			bit [8:0]      lvl_idx [4];
			bit [5:0]      cur;
			bit [5:0]      np;
			bit [63:0]     e;
			bit [51:0]     fr;
			bit [39:0]     frm;
			bit            ok;
			r.status = STAT_OK;
			r.leaf   = '0;
			r.made   = '0;
			r.rdata  = '0;
			if (cmd == CMD_READ) begin
				r.rdata = words[{rpg, rix}];
				n_read++;
			end else begin
				lvl_idx[0] = va[47:39];
				lvl_idx[1] = va[38:30];
				lvl_idx[2] = va[29:21];
				lvl_idx[3] = va[20:12];
				cur = root_pg;
				ok  = 1'b1;
				for (int l = 0; l < 3 && ok; l++) begin
					e = words[{cur, lvl_idx[l]}];
					if (e == 0) begin
						if (!grab_page(np)) begin
							r.status = STAT_NO_PAGE;
							ok = 1'b0;
						end else begin
							frm = base_frame + 40'(np);
							words[{cur, lvl_idx[l]}] = {12'h000, frm, ENTRY_FLAGS};
							r.made++;
							cur = np;
						end
					end else begin
						fr = e[63:12];
						if (fr < 52'(base_frame) || fr - 52'(base_frame) >= 52'(PAGES)) begin
							r.status = STAT_BAD_FRM;
							ok = 1'b0;
						end else begin
							cur = 6'(fr - 52'(base_frame));
						end
					end
				end
				if (ok) begin
					if (!grab_page(np)) begin
						r.status = STAT_NO_PAGE;
					end else begin
						r.leaf = base_frame + 40'(np);
						words[{cur, lvl_idx[3]}] = {12'h000, r.leaf, ENTRY_FLAGS};
					end
				end
				n_map++;
				tables_total += r.made;
				stat_cnt[r.status]++;
			end
			pending_outcomes.push_back(r);
		endfunction

		function void mismatch(string field, bit [63:0] exp_v, logic [63:0] act_v);
			errors++;
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
		endfunction

		function void check_outcome(logic [111:0] d);
			walk_outcome_t r;
			if (pending_outcomes.size() == 0) begin
				errors++;
				$error("result transfer with no command outstanding: 0x%0h", d);
				return;
			end
			r = pending_outcomes.pop_front();
			if (d[1:0] !== r.status)
				mismatch("status", 64'(r.status), 64'(d[1:0]));
			if (d[41:2] !== r.leaf)
				mismatch("leaf_frame", 64'(r.leaf), 64'(d[41:2]));
			if (d[43:42] !== r.made)
				mismatch("tables_made", 64'(r.made), 64'(d[43:42]));
			if (d[107:44] !== r.rdata)
				mismatch("read_data", r.rdata, d[107:44]);
		endfunction
	endclass

	logic         clk         = 1'b0;
	logic         arst_n      = 1'b0;
	logic         s_tvalid    = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata     = '0;
	logic         s_tuser     = 1'b0;
	logic         m_tvalid;
	logic         m_tready    = 1'b0;
	logic [111:0] m_tdata;
	logic         cfg_valid   = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index   = '0;
	logic [39:0]  cfg_data    = '0;

	walk_shadow walk = new();

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int settings     = 0;
	bit [8:0] hot [4];

	page_table_map_with_allocation #(
		.PAGE_COUNT(PAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			walk.check_outcome(m_tdata);
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, walk.pending_outcomes.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_cmd(cmd_t c, bit [47:0] va, bit [5:0] pg, bit [8:0] ix);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {1'b0, ix, pg, va};
		do @(posedge clk); while (s_tready !== 1'b1);
		walk.note_command(c, va, pg, ix);
	endtask

	task automatic map_va(bit [47:0] va);
		send_cmd(CMD_MAP, va, 6'($urandom), 9'($urandom));
	endtask

	task automatic read_word(bit [5:0] pg, bit [8:0] ix);
		send_cmd(CMD_READ, 48'({$urandom, $urandom}), pg, ix);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (walk.pending_outcomes.size() != 0);
	endtask

	task automatic cfg_write(reg_idx_t idx, bit [39:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		walk.write_reg(idx, val);
	endtask

	// upper data bits of the 6-bit registers are junk on purpose
	task automatic set_regs(bit [5:0] root, bit [39:0] base, bit [5:0] first, bit [5:0] last);
		drain();
		cfg_write(REG_ROOT_PAGE, {34'({$urandom, $urandom}), root});
		cfg_write(REG_POOL_BASE, base);
		cfg_write(REG_FREE_FIRST, {34'({$urandom, $urandom}), first});
		cfg_write(REG_FREE_LAST, {34'({$urandom, $urandom}), last});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic bit [8:0] pick_index();
		if ($urandom_range(9) < 7)
			return hot[$urandom_range(3)];
		return 9'($urandom);
	endfunction

	initial begin
		bit [5:0]  root;
		bit [39:0] base;
		bit [5:0]  first;
		bit [5:0]  last;
		bit [5:0]  pg;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// store clear runs with s_tready low
		do @(posedge clk); while (s_tready !== 1'b1);

		// directed corner cases
		set_regs(6'd0, 40'h100, 6'd1, 6'd63);
		read_word(6'd0, 9'd0);
		map_va(48'h0000_0000_0000);             // three new tables plus leaf
		map_va(48'hFFFF_FFFF_F000);             // all indices at their maximum
		map_va(48'h0000_0000_0000);             // follows the existing path
		map_va(48'h0000_0000_1FFF);             // offset bits ignored
		map_va(48'h0080_4020_1ABC);
		read_word(6'd0, 9'd0);
		read_word(6'd0, 9'd511);
		read_word(6'd63, 9'd511);
		read_word(6'd1, 9'd0);
		set_regs(6'd0, 40'h100, 6'd60, 6'd61);  // allocator runs dry mid-walk
		map_va(48'h1234_5678_9000);
		map_va(48'h1234_5678_9000);
		set_regs(6'd0, 40'h100, 6'd10, 6'd5);   // empty free range
		map_va(48'h0000_0000_0000);
		set_regs(6'd0, 40'h200, 6'd1, 6'd63);   // old frames below the pool
		map_va(48'h0000_0000_0000);
		set_regs(6'd0, 40'h80, 6'd1, 6'd63);    // old frames above the pool
		map_va(48'h0000_0000_0000);
		set_regs(6'd62, 40'hFF_FFFF_FFFE, 6'd1, 6'd63);  // frame numbers wrap
		map_va(48'h0000_0000_0000);
		map_va(48'h0000_0000_0000);
		set_regs(6'd63, 40'hFF_FFFF_FFFF, 6'd62, 6'd63); // allocator reuses the root
		map_va(48'hFFFF_FFFF_FFFF);
		read_word(6'd63, 9'd511);
		read_word(6'd62, 9'd511);
		map_va(48'h0000_0000_0000);

		// random phases
		for (int ph = 0; ph < PHASES; ph++) begin
			root  = walk.root_pg;
			base  = walk.base_frame;
			case ($urandom_range(9))
				0: root = 6'd0;
				1: root = 6'd63;
				2, 3, 4: root = 6'($urandom);
				default: ;
			endcase
			case ($urandom_range(9))
				0: base = '0;
				1: base = 40'hFF_FFFF_FFFF;
				2: base = 40'hFF_FFFF_FFFF - 40'($urandom_range(63));
				3: base = 40'({$urandom, $urandom});
				default: ;
			endcase
			case ($urandom_range(9))
				0: first = 6'd0;
				1: first = 6'd63;
				2: first = 6'($urandom);
				default: first = 6'($urandom_range(4));
			endcase
			case ($urandom_range(9))
				0: last = 6'd0;
				1: last = 6'($urandom);
				default: last = 6'd63;
			endcase
			set_regs(root, base, first, last);
			case ($urandom_range(2))
				0: hot[0] = 9'd0;
				1: hot[0] = 9'd511;
				default: hot[0] = 9'($urandom);
			endcase
			for (int h = 1; h < 4; h++)
				hot[h] = 9'($urandom);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
				default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
			endcase
			// back-pressure: result side blocked while commands keep coming
			if (ph == 0)
				hold_left = HOLD_CYCLES;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 6 && k == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(99) < 25) begin
					case ($urandom_range(9))
						0, 1, 2, 3: pg = walk.root_pg;
						4, 5, 6: pg = 6'($urandom);
						default: pg = 6'(walk.next_pg - 7'd1);
					endcase
					read_word(pg, ($urandom_range(1)) ? pick_index() : 9'($urandom));
				end else begin
					map_va({pick_index(), pick_index(), pick_index(), pick_index(),
						12'($urandom)});
				end
			end
		end

		drain();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		repeat (40) @(posedge clk);
		$display("run: %0d maps and %0d reads under %0d register settings, four idle patterns",
			walk.n_map, walk.n_read, settings);
		$display("maps: %0d ok, %0d out of pages, %0d bad frame, %0d tables allocated",
			walk.stat_cnt[STAT_OK], walk.stat_cnt[STAT_NO_PAGE], walk.stat_cnt[STAT_BAD_FRM],
			walk.tables_total);
		if (walk.errors == 0 && walk.pending_outcomes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", walk.errors,
				walk.pending_outcomes.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== page_table_map_with_allocation.f =====
rtl/core/ptm_pkg.sv
rtl/core/ptm_ram.sv
rtl/core/page_table_map_with_allocation.sv
bench/tb.sv
